// ----- rtl/xtea_block_cipher_defines.svh -----
// ---------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define XT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xtea check failed");
// next-cycle implication
`define XT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xtea check failed");
`else
`define XT_ASSERT_NOW(label, ante, cons)
`define XT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/xtea_pkg.sv -----
// ---------------------------------------------------------------------------
// XTEA package
// Request and result types, key register indexes and round helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

    localparam int          ROUNDS     = 32;
    localparam int          HALF_STEPS = 2 * ROUNDS;
    localparam logic [31:0] DELTA      = 32'h9E37_79B9;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 4'd3;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] block_lo;
        logic [31:0] block_hi;
    } t_xtea_in;

    typedef struct packed {
        logic [31:0] out_lo;
        logic [31:0] out_hi;
    } t_xtea_out;

    typedef struct packed {
        logic        cmd;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_xtea_stage;

    function automatic logic [31:0] xt_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Sum multiple k times DELTA, modulo 2^32
    function automatic logic [31:0] xt_sum_of(input int k);
        logic [63:0] p;
        p = 64'(k) * 64'(DELTA);
        return p[31:0];
    endfunction

    // Running sum seen by half step h, encrypt direction
    function automatic logic [31:0] xt_sum_enc(input int h);
        return xt_sum_of((h + 1) / 2);
    endfunction

    // Running sum seen by half step h, decrypt direction
    function automatic logic [31:0] xt_sum_dec(input int h);
        return xt_sum_of(ROUNDS - (h + 1) / 2);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/xtea_block_cipher.sv -----
// ---------------------------------------------------------------------------
// XTEA block cipher
// Fully unrolled 64-bit XTEA encrypt/decrypt pipeline, one half round per
// stage, key held in four configuration registers.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_stall      i_in_data  (t_xtea_in)
//  out       source     o_out_valid / i_out_stall    o_out_data (t_xtea_out)
//  cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  One request enters per cycle while the skid register is empty; the
//  path is an input register, then one register per half round.
//  Each half round stage holds one mix, one key add and one add/subtract.
//  A two-entry output (last stage plus skid register) keeps o_in_stall
//  registered; the whole pipeline holds while the skid register is full.
//  Reset is synchronous; it clears the valid bits and the key words.
// ---------------------------------------------------------------------------
`default_nettype none

`include "xtea_block_cipher_defines.svh"

module xtea_block_cipher (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire xtea_pkg::t_xtea_in                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output xtea_pkg::t_xtea_out                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [xtea_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data
);

    localparam int NH = xtea_pkg::HALF_STEPS;

    logic [31:0]           r_key [4];
    logic [NH:0]           r_valid;
    xtea_pkg::t_xtea_stage r_stage [NH+1];
    xtea_pkg::t_xtea_stage n_stage [NH+1];
    logic                  r_skid_valid;
    xtea_pkg::t_xtea_out   r_skid;
    logic                  w_adv;
    logic                  w_in_acc;

    assign w_adv       = !r_skid_valid;
    assign w_in_acc    = i_in_valid && w_adv;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                xtea_pkg::CFG_KEY_WORD0: r_key[0] <= i_cfg_data;
                xtea_pkg::CFG_KEY_WORD1: r_key[1] <= i_cfg_data;
                xtea_pkg::CFG_KEY_WORD2: r_key[2] <= i_cfg_data;
                xtea_pkg::CFG_KEY_WORD3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_comb begin
        n_stage[0].cmd = i_in_data.command;
        n_stage[0].v0  = i_in_data.block_lo;
        n_stage[0].v1  = i_in_data.block_hi;
    end

    // one half round per stage
    for (genvar g = 0; g < NH; g++) begin : g_half
        localparam logic [31:0] SUM_E = xtea_pkg::xt_sum_enc(g);
        localparam logic [31:0] SUM_D = xtea_pkg::xt_sum_dec(g);
        localparam logic        ODD   = 1'((g % 2) == 1);
        localparam logic [1:0]  IDX_E = ODD ? SUM_E[12:11] : SUM_E[1:0];
        localparam logic [1:0]  IDX_D = ODD ? SUM_D[1:0]   : SUM_D[12:11];

        logic        w_upd_v1;
        logic        w_dec;
        logic [31:0] w_src;
        logic [31:0] w_dst;
        logic [31:0] w_sum;
        logic [31:0] w_key;
        logic [31:0] w_f;
        logic [31:0] w_res;

        always_comb begin
            w_dec    = (r_stage[g].cmd == xtea_pkg::CMD_DECRYPT);
            // encrypt even and decrypt odd steps update v0
            w_upd_v1 = r_stage[g].cmd ^ ODD;
            w_src    = w_upd_v1 ? r_stage[g].v0 : r_stage[g].v1;
            w_dst    = w_upd_v1 ? r_stage[g].v1 : r_stage[g].v0;
            w_sum    = w_dec ? SUM_D : SUM_E;
            w_key    = w_dec ? r_key[IDX_D] : r_key[IDX_E];
            w_f      = xtea_pkg::xt_mix(w_src) ^ (w_sum + w_key);
            w_res    = w_dec ? (w_dst - w_f) : (w_dst + w_f);
            n_stage[g+1] = r_stage[g];
            if (w_upd_v1) begin
                n_stage[g+1].v1 = w_res;
            end else begin
                n_stage[g+1].v0 = w_res;
            end
        end
    end

    // pipeline advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[NH-1:0], w_in_acc};
        end
    end

    for (genvar s = 0; s <= NH; s++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_stage[s] <= n_stage[s];
            end
        end
    end

    // skid register: catch the last stage when the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_adv) begin
            r_skid_valid <= r_valid[NH] && i_out_stall;
        end else if (!i_out_stall) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_skid.out_lo <= r_stage[NH].v0;
            r_skid.out_hi <= r_stage[NH].v1;
        end
    end

    always_comb begin
        o_out_valid = r_skid_valid || r_valid[NH];
        if (r_skid_valid) begin
            o_out_data = r_skid;
        end else begin
            o_out_data.out_lo = r_stage[NH].v0;
            o_out_data.out_hi = r_stage[NH].v1;
        end
    end

    `XT_ASSERT_NEXT(a_in_to_stage0, i_in_valid && !o_in_stall, r_valid[0])
    `XT_ASSERT_NEXT(a_hold_when_full, r_skid_valid, $stable(r_valid))
    `XT_ASSERT_NOW(a_skid_fill_cause, $rose(r_skid_valid), $past(r_valid[NH] && i_out_stall))
    `XT_ASSERT_NEXT(a_skid_keeps, r_skid_valid && i_out_stall,
                    r_skid_valid && $stable(r_skid))

endmodule

`default_nettype wire
